FILE: rtl/pfa_pkg.sv
// shared types, constants and codes of the page frame allocator
package pfa_pkg;

    localparam int FRAMES_DEF = 16;

    localparam int NUM_W   = 5;
    localparam int PID_W   = 16;
    localparam int TIME_W  = 32;
    localparam int STAMP_W = 36;
    localparam int TICK_W  = 6;
    localparam int FRAME_W = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [NUM_W-1:0] FIU_RESET = 5'd10;

    // register indexes
    localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

    // commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        KIND_EVICT   = 2'd0,
        KIND_LOAD    = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_SCAN,
        S_EV_SCAN,
        S_EV_EMIT,
        S_LD_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              command;
        logic [PID_W-1:0]  proc_id;
        logic [NUM_W-1:0]  pages_wanted;
        logic [TIME_W-1:0] time_now;
    } req_word_t;

    typedef struct packed {
        kind_t              kind;
        logic [FRAME_W-1:0] frame;
        logic [PID_W-1:0]   owner;
        logic [NUM_W-1:0]   free_frames;
        logic [TICK_W-1:0]  load_ticks;
        logic               last;
    } rsp_word_t;

endpackage

FILE: rtl/pfa_if.sv
// request and response channel interfaces of the page frame allocator
interface pfa_req_if import pfa_pkg::*;;
    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*;;
    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/page_frame_allocator_oldest_evict_top.sv
// page frame allocator with oldest-first eviction, top level
//
//  channel  dir   handshake          word
//  -------  ----  -----------------  ------------------------------------------------
//  req      in    valid / ready      command, proc_id, pages_wanted, time_now
//  rsp      out   valid / ready      kind, frame, owner, free_frames, load_ticks, last
//  apb      in    psel/penable/pwr   frames_in_use at byte address 0
//
// one request at a time; req.ready is high only while the sequencer is idle
// a release is one pass over the n usable frames, one frame compared per cycle
// while rsp does not stall; a load with e evictions makes e full passes of the shared
// 36-bit stamp comparator over the table, then an eviction report pass and a load pass
// rsp stalls hold the release, report and load passes; rst_n clears the table at once
module page_frame_allocator_oldest_evict_top import pfa_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // word channels
    pfa_req_if.sink           req,
    pfa_rsp_if.source         rsp
);

    localparam int IDX_W = $clog2(FRAMES);
    // at most 16 frames are addressable by the 4-bit frame field
    localparam logic [NUM_W-1:0] USE_CAP = NUM_W'((FRAMES < 16) ? FRAMES : 16);

    // usable frame count: register value saturated to 1..USE_CAP
    function automatic logic [NUM_W-1:0] usable(input logic [NUM_W-1:0] v);
        return (v == '0) ? NUM_W'(1) : ((v > USE_CAP) ? USE_CAP : v);
    endfunction

    // control state
    state_t             state_reg, state_next;
    logic [NUM_W-1:0]   frames_reg, frames_next;
    logic [FRAMES-1:0]  valid_reg, valid_next;
    logic [FRAMES-1:0]  evict_reg, evict_next;
    logic [NUM_W-1:0]   free_reg, free_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    // per-request working registers
    logic               cmd_reg, cmd_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [NUM_W-1:0]   want_reg, want_next;
    logic [NUM_W-1:0]   need_reg, need_next;
    logic [NUM_W-1:0]   loaded_reg, loaded_next;
    logic [STAMP_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic               found_reg, found_next;
    rsp_word_t          out_word_reg;

    // frame table payload
    logic [PID_W-1:0]   owner_mem [FRAMES];
    logic [STAMP_W-1:0] stamp_mem [FRAMES];

    logic               ld_we;
    logic [STAMP_W-1:0] ld_stamp;

    logic               emit;
    rsp_word_t          emit_word;

    logic               accept;
    logic               cfg_we;
    logic [NUM_W-1:0]   n_use;
    logic               out_free;
    logic               idx_last;

    // current table entry under the scan pointer; payload registered from the next pointer
    logic               cur_valid;
    logic [PID_W-1:0]   cur_owner_reg;
    logic [STAMP_W-1:0] cur_stamp_reg;
    logic               cur_evict;

    logic               better;
    logic [IDX_W-1:0]   best_i;
    logic               found_i;
    logic               rel_hit;
    logic               ld_hit;

    logic [NUM_W-1:0]   want_sat;
    logic [NUM_W-1:0]   need_in;
    logic [STAMP_W-1:0] now_ext;

    // handshakes
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    // apb: pready tied high, one register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2:2] == REG_FRAMES_IN_USE);
    assign prdata = (paddr[2:2] == REG_FRAMES_IN_USE) ? DATA_W'(frames_reg) : '0;

    assign n_use    = usable(frames_reg);
    assign idx_last = (NUM_W'(idx_reg) == (n_use - NUM_W'(1)));

    assign cur_valid = valid_reg[idx_reg];
    assign cur_evict = evict_reg[idx_reg];

    // shared stamp comparator: strict less keeps the lowest index on ties
    assign better  = cur_valid && (!found_reg || (cur_stamp_reg < best_stamp_reg));
    assign best_i  = better ? idx_reg : best_reg;
    assign found_i = found_reg || better;

    assign rel_hit = cur_valid && (cur_owner_reg == pid_reg);
    assign ld_hit  = !cur_valid && (loaded_reg < want_reg);

    // request decode: saturate the page count, work out how many to evict
    assign want_sat = (req.data.pages_wanted > n_use) ? n_use : req.data.pages_wanted;
    assign need_in  = (want_sat > free_reg) ? (want_sat - free_reg) : '0;
    // time widened to 36 bits, so time * 10 as the sum of two shifts never wraps
    assign now_ext  = STAMP_W'(req.data.time_now);
    assign ld_stamp = base_reg + STAMP_W'(loaded_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.command == CMD_RELEASE)
                        state_next = S_REL_SCAN;
                    else if (need_in != '0)
                        state_next = S_EV_SCAN;
                    else
                        state_next = S_EV_EMIT;
                end
            end
            S_REL_SCAN:
            begin
                if (out_free && idx_last)
                    state_next = S_DONE;
            end
            S_EV_SCAN:
            begin
                // stop after the last eviction or when nothing is left to evict
                if (idx_last && (!found_i || (need_reg == NUM_W'(1))))
                    state_next = S_EV_EMIT;
            end
            S_EV_EMIT:
            begin
                if (out_free && idx_last)
                    state_next = S_LD_SCAN;
            end
            S_LD_SCAN:
            begin
                if (out_free && idx_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        frames_next     = frames_reg;
        valid_next      = valid_reg;
        evict_next      = evict_reg;
        free_next       = free_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        want_next       = want_reg;
        need_next       = need_reg;
        loaded_next     = loaded_reg;
        base_next       = base_reg;
        best_next       = best_reg;
        best_stamp_next = best_stamp_reg;
        found_next      = found_reg;
        ld_we           = 1'b0;
        emit            = 1'b0;
        emit_word       = '{kind: KIND_DONE, frame: '0, owner: pid_reg,
                            free_frames: '0, load_ticks: '0, last: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.data.command;
                    pid_next    = req.data.proc_id;
                    want_next   = want_sat;
                    need_next   = need_in;
                    loaded_next = '0;
                    base_next   = (now_ext << 3) + (now_ext << 1);
                    idx_next    = '0;
                    found_next  = 1'b0;
                end
            end
            S_REL_SCAN:
            begin
                if (out_free)
                begin
                    if (rel_hit)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        free_next           = free_reg + NUM_W'(1);
                        emit                = 1'b1;
                        emit_word.kind      = KIND_RELEASE;
                        emit_word.frame     = FRAME_W'(idx_reg);
                    end
                    idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            S_EV_SCAN:
            begin
                if (idx_last)
                begin
                    if (found_i)
                    begin
                        valid_next[best_i] = 1'b0;
                        evict_next[best_i] = 1'b1;
                        free_next          = free_reg + NUM_W'(1);
                        need_next          = need_reg - NUM_W'(1);
                    end
                    idx_next   = '0;
                    found_next = 1'b0;
                end
                else
                begin
                    idx_next        = idx_reg + IDX_W'(1);
                    best_next       = best_i;
                    found_next      = found_i;
                    best_stamp_next = better ? cur_stamp_reg : best_stamp_reg;
                end
            end
            S_EV_EMIT:
            begin
                if (out_free)
                begin
                    if (cur_evict)
                    begin
                        evict_next[idx_reg] = 1'b0;
                        emit                = 1'b1;
                        emit_word.kind      = KIND_EVICT;
                        emit_word.frame     = FRAME_W'(idx_reg);
                        emit_word.owner     = cur_owner_reg;
                    end
                    idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            S_LD_SCAN:
            begin
                if (out_free)
                begin
                    if (ld_hit)
                    begin
                        valid_next[idx_reg] = 1'b1;
                        ld_we               = 1'b1;
                        loaded_next         = loaded_reg + NUM_W'(1);
                        free_next           = free_reg - NUM_W'(1);
                        emit                = 1'b1;
                        emit_word.kind      = KIND_LOAD;
                        emit_word.frame     = FRAME_W'(idx_reg);
                    end
                    idx_next = idx_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_word.kind        = KIND_DONE;
                    emit_word.free_frames = free_reg;
                    // two ticks per loaded page, zero on release
                    emit_word.load_ticks  = (cmd_reg == CMD_LOAD) ?
                                            {loaded_reg, 1'b0} : '0;
                    emit_word.last        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // register write clears the table; the user must write it only while idle, the block does not enforce this
        if (cfg_we)
        begin
            frames_next = pwdata[NUM_W-1:0];
            valid_next  = '0;
            evict_next  = '0;
            free_next   = usable(pwdata[NUM_W-1:0]);
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !rsp.ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frames_reg    <= FIU_RESET;
            valid_reg     <= '0;
            evict_reg     <= '0;
            free_reg      <= usable(FIU_RESET);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            valid_reg     <= valid_next;
            evict_reg     <= evict_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pid_reg        <= pid_next;
        want_reg       <= want_next;
        need_reg       <= need_next;
        loaded_reg     <= loaded_next;
        base_reg       <= base_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        if (emit)
            out_word_reg <= emit_word;
    end

    // frame table owner and stamp, written by the load pass
    // read at the next scan position so the entry is ready when the pointer gets there
    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            owner_mem[idx_reg] <= pid_reg;
            stamp_mem[idx_reg] <= ld_stamp;
        end
        cur_owner_reg <= owner_mem[idx_next];
        cur_stamp_reg <= stamp_mem[idx_next];
    end

    // frames inside the usable range, for the free count check
    logic [FRAMES-1:0] use_mask;
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
            use_mask[i] = (i < int'(n_use));
    end

    // a word is only produced when the output register can take it
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || rsp.ready))
        else $error("word produced into a full output register");

    // the running free count agrees with the valid bits between requests
    a_free_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(~valid_reg & use_mask) == int'(free_reg)))
        else $error("free count out of step with the frame table");

    // eviction marks are all reported before the next request
    a_evict_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (evict_reg == '0))
        else $error("eviction mark left behind");

    // the eviction search only runs while frames are still missing
    a_need_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_SCAN) |-> (need_reg != '0))
        else $error("eviction search with nothing to evict");

endmodule

FILE: sim/tb_page_frame_allocator_oldest_evict_top.sv
// testbench of the page frame allocator with oldest-first eviction
`timescale 1ns / 1ps

import pfa_pkg::*;

class frame_alloc_scoreboard;
    logic [NUM_W-1:0]   fiu_reg;
    bit                 busy [16];
    logic [PID_W-1:0]   owner_of [16];
    logic [STAMP_W-1:0] stamp_of [16];
    rsp_word_t          pending_reports [$];
    int                 mismatches;
    int                 n_requests;
    int                 n_words;
    int                 n_evicted;
    int                 n_loaded;
    int                 n_released;

    function new();
        reset_table(FIU_RESET);
    endfunction

    function void reset_table(input logic [NUM_W-1:0] v);
        fiu_reg = v;
        foreach (busy[i])
            busy[i] = 1'b0;
    endfunction

    // usable frames: register saturated to 1..min(FRAMES,16)
    function int usable();
        int n;
        int cap;
        cap = (FRAMES_DEF < 16) ? FRAMES_DEF : 16;
        n = fiu_reg;
        if (n < 1)
            n = 1;
        if (n > cap)
            n = cap;
        return n;
    endfunction

    function void queue_report(input kind_t k, input int frame, input logic [PID_W-1:0] who,
                               input int free_n, input int ticks, input bit last);
        rsp_word_t r;
        r.kind        = k;
        r.frame       = FRAME_W'(frame);
        r.owner       = who;
        r.free_frames = NUM_W'(free_n);
        r.load_ticks  = TICK_W'(ticks);
        r.last        = last;
        pending_reports.push_back(r);
    endfunction

    // works out the words one accepted request causes, in order
    function void note_request(input req_word_t w);
        int n;
        int want;
        int nfree;
        int loaded;
        int best;
        bit gone [16];
        n = usable();
        loaded = 0;
        n_requests++;
        if (w.command == CMD_RELEASE) begin
            for (int i = 0; i < n; i++) begin
                if (busy[i] && owner_of[i] == w.proc_id) begin
                    busy[i] = 1'b0;
                    n_released++;
                    queue_report(KIND_RELEASE, i, w.proc_id, 0, 0, 1'b0);
                end
            end
        end else begin
            want = w.pages_wanted;
            if (want > n)
                want = n;
            nfree = 0;
            for (int i = 0; i < 16; i++)
                gone[i] = 1'b0;
            for (int i = 0; i < n; i++)
                if (!busy[i])
                    nfree++;
            // oldest stamp goes first, lowest index wins a tie
            while (nfree < want) begin
                best = -1;
                for (int i = 0; i < n; i++)
                    if (busy[i] && (best < 0 || stamp_of[i] < stamp_of[best]))
                        best = i;
                if (best < 0)
                    break;
                busy[best] = 1'b0;
                gone[best] = 1'b1;
                nfree++;
            end
            for (int i = 0; i < n; i++) begin
                if (gone[i]) begin
                    n_evicted++;
                    queue_report(KIND_EVICT, i, owner_of[i], 0, 0, 1'b0);
                end
            end
            for (int i = 0; i < n && loaded < want; i++) begin
                if (!busy[i]) begin
                    busy[i]     = 1'b1;
                    owner_of[i] = w.proc_id;
                    stamp_of[i] = STAMP_W'(w.time_now) * STAMP_W'(10) + STAMP_W'(loaded);
                    loaded++;
                    n_loaded++;
                    queue_report(KIND_LOAD, i, w.proc_id, 0, 0, 1'b0);
                end
            end
        end
        nfree = 0;
        for (int i = 0; i < n; i++)
            if (!busy[i])
                nfree++;
        queue_report(KIND_DONE, 0, w.proc_id, nfree, loaded * 2, 1'b1);
    endfunction

    function string show(input rsp_word_t r);
        return $sformatf("kind=%0d frame=%0d owner=%h free=%0d ticks=%0d last=%b",
                         r.kind, r.frame, r.owner, r.free_frames, r.load_ticks, r.last);
    endfunction

    function void check_report(input rsp_word_t got);
        rsp_word_t want;
        if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word, nothing pending: %s", show(got));
            return;
        end
        want = pending_reports.pop_front();
        n_words++;
        if (got.kind !== want.kind || got.frame !== want.frame || got.owner !== want.owner ||
            got.free_frames !== want.free_frames || got.load_ticks !== want.load_ticks ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at word %0d: expected %s, got %s",
                         n_words, show(want), show(got));
        end
    endfunction
endclass

module tb_page_frame_allocator_oldest_evict_top;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 180;
    localparam int PHASES       = 8;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pfa_req_if req_if ();
    pfa_rsp_if rsp_if ();

    frame_alloc_scoreboard sb;

    bit                idling = 1'b1;
    int                cycles = 0;
    int                stall_left = 0;
    int                configs = 0;
    logic [TIME_W-1:0] tick_now = '0;
    logic [PID_W-1:0]  pid_pool [6] = '{16'h0000, 16'h0001, 16'h0002, 16'h1234,
                                        16'h8000, 16'hFFFF};
    logic [NUM_W-1:0]  fiu_plan [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd4, 5'd7, 5'd10,
                                             5'd16};

    page_frame_allocator_oldest_evict_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("page_frame_allocator_oldest_evict_top test failed");
            $finish;
        end
    end

    // receiver: ready drops in bursts of random length while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_if.ready  <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready  <= 1'b1;
        end
    end

    // every accepted result word goes against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_report(rsp_if.data);
    end

    function automatic req_word_t req_of(input logic cmd, input logic [PID_W-1:0] pid,
                                         input logic [NUM_W-1:0] pages,
                                         input logic [TIME_W-1:0] t);
        req_word_t w;
        w.command      = cmd;
        w.proc_id      = pid;
        w.pages_wanted = pages;
        w.time_now     = t;
        return w;
    endfunction

    // one request word; an optional gap first, then hold valid until ready
    task automatic send_word(input req_word_t w);
        int gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(w);
    endtask

    // sender holds off until every predicted word has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // setup then access cycle; the register takes the value at the access edge
    task automatic write_frames_in_use(input logic [NUM_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_FRAMES_IN_USE);
        pwdata  <= (DATA_W'($urandom) << NUM_W) | DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.reset_table(v);
        configs++;
        @(posedge clk);
    endtask

    // hand-picked requests, run with the reset value of ten frames
    task automatic run_directed();
        send_word(req_of(CMD_LOAD,    16'h0001, 5'd3,  32'd0));
        // zero pages: done word only
        send_word(req_of(CMD_LOAD,    16'h0002, 5'd0,  32'd1));
        // release of a process that owns nothing
        send_word(req_of(CMD_RELEASE, 16'd99,   5'd31, 32'd1));
        // oversized request, saturates and evicts the three oldest
        send_word(req_of(CMD_LOAD,    16'hFFFF, 5'd31, 32'd2));
        send_word(req_of(CMD_RELEASE, 16'hFFFF, 5'd0,  32'd3));
        // two frames stamped alike, then a full table: tie goes to lowest index
        send_word(req_of(CMD_LOAD,    16'h0003, 5'd1,  32'd100));
        send_word(req_of(CMD_LOAD,    16'h0004, 5'd1,  32'd100));
        send_word(req_of(CMD_LOAD,    16'h0005, 5'd8,  32'd101));
        send_word(req_of(CMD_LOAD,    16'h0006, 5'd1,  32'd102));
        // largest time evicts everything, then an earlier time is oldest-loaded last
        send_word(req_of(CMD_LOAD,    16'h0007, 5'd16, 32'hFFFF_FFFF));
        send_word(req_of(CMD_LOAD,    16'h0008, 5'd2,  32'd0));
        send_word(req_of(CMD_RELEASE, 16'h0007, 5'd16, 32'd0));
        send_word(req_of(CMD_LOAD,    16'h0000, 5'd16, 32'd5));
        send_word(req_of(CMD_RELEASE, 16'h0000, 5'd0,  32'd6));
        send_word(req_of(CMD_RELEASE, 16'h0008, 5'd0,  32'd6));
        send_word(req_of(CMD_LOAD,    16'h5A5A, 5'd17, 32'hA5A5_A5A5));
        send_word(req_of(CMD_LOAD,    16'hA5A5, 5'd15, 32'h5A5A_5A5A));
        send_word(req_of(CMD_RELEASE, 16'h5A5A, 5'd0,  32'd7));
    endtask

    // mostly loads and releases over a small set of processes, so tables fill,
    // evict and drain; a few foreign ids, oversized counts and time jumps
    task automatic run_random(input int count);
        req_word_t w;
        int        n;
        int        roll;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                wait_drained();
            n = sb.usable();
            roll = $urandom_range(0, 99);
            w.command = (roll < 25) ? CMD_RELEASE : CMD_LOAD;
            if ($urandom_range(0, 9) < 8)
                w.proc_id = pid_pool[$urandom_range(0, 5)];
            else
                w.proc_id = PID_W'($urandom);
            roll = $urandom_range(0, 19);
            if (roll < 14)
                w.pages_wanted = NUM_W'($urandom_range(0, n));
            else if (roll < 17)
                w.pages_wanted = NUM_W'(n);
            else
                w.pages_wanted = NUM_W'($urandom_range(0, 31));
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                w.time_now = $urandom;
            end else if (roll == 1) begin
                w.time_now = '1;
            end else begin
                // repeated times give stamp ties across requests
                tick_now   = tick_now + TIME_W'($urandom_range(0, 2));
                w.time_now = tick_now;
            end
            send_word(w);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        // one setting per phase; the value of phase 5 is drawn at random
        fiu_plan[5] = NUM_W'($urandom_range(2, 15));
        for (int p = 0; p < PHASES; p++) begin
            // the final phase runs both sides flat out
            if (p == PHASES - 1)
                idling = 1'b0;
            write_frames_in_use(fiu_plan[p]);
            run_random(RANDOM_ITEMS / PHASES);
            wait_drained();
        end

        // settle for a while in case a stray word follows
        repeat (40) @(posedge clk);

        $display("covered %0d requests over %0d register settings, %0d result words",
                 sb.n_requests, configs + 1, sb.n_words);
        $display("frames evicted %0d, loaded %0d, released %0d",
                 sb.n_evicted, sb.n_loaded, sb.n_released);
        if (sb.pending_reports.size() != 0)
            $display("%0d predicted words never arrived", sb.pending_reports.size());
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
            $display("page_frame_allocator_oldest_evict_top test passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("page_frame_allocator_oldest_evict_top test failed");
        end
        $finish;
    end

endmodule
